// File: design/swept_box_collision_side_unit_macros.svh
// Assertion macros for the swept box collision side unit.
// Included by design/swept_box_collision_side_unit.sv; no other dependencies.
`ifndef SWEPT_BOX_COLLISION_SIDE_UNIT_MACROS_SVH
`define SWEPT_BOX_COLLISION_SIDE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBCS_ASSERT_IMPLY(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("sbcs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBCS_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("sbcs assertion failed");

`endif

// File: design/sbcs_pkg.sv
// Package for the swept box collision side unit: widths and face codes.
// No dependencies.
package sbcs_pkg;

    localparam int COORD_W = 24;
    localparam int EXT_W   = 20;
    localparam int LINE_W  = 26;
    localparam int DIFF_W  = 27;
    localparam int VEL_W   = 25;
    localparam int PROD_W  = DIFF_W + VEL_W;
    localparam int IN_W    = 8 * COORD_W + 4 * EXT_W;
    localparam int SIDE_W  = 3;
    localparam int OUT_W   = 8;

    localparam logic [SIDE_W-1:0] SIDE_NONE   = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd4;

endpackage

// File: design/swept_box_collision_side_unit.sv
// Swept box collision side unit: four-stage pipeline, one pair test per beat.
// Depends on sbcs_pkg and swept_box_collision_side_unit_macros.svh.
//
//  channel | dir | width | contents
//  s_      | in  | 272   | mover, next, velocity, obstacle (24b each), four extents (20b)
//  m_      | out | 8     | hit_side in bits 2:0, rest zero
//
// Each beat is registered in every stage; one beat per cycle while m_tready is high.
// Stage 1 registers the beat, stage 2 holds line differences and crossing
// flags, stage 3 the eight exact cross products (27x25 bits), stage 4 the face.
// Each stage takes a new beat whenever it is empty or its successor moves, so
// bubbles collapse under back-pressure; a held result stalls the input once
// all four stages are full. Synchronous active-low reset clears valid bits only.
`include "swept_box_collision_side_unit_macros.svh"

module swept_box_collision_side_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // mover_x, mover_y, mover_next_x, mover_next_y, velocity_x, velocity_y,
    // obstacle_x, obstacle_y, extent_top, extent_bottom, extent_left, extent_right
    input  logic [sbcs_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // hit_side, then zero padding
    output logic [sbcs_pkg::OUT_W-1:0] m_tdata
);

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    assign r4 = !v4_reg || m_tready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign s_tready = r1;

    // stage 1: raw fields
    logic signed [sbcs_pkg::COORD_W-1:0] px_reg, py_reg, nx_reg, ny_reg;
    logic signed [sbcs_pkg::COORD_W-1:0] vx_reg, vy_reg, ox_reg, oy_reg;
    logic        [sbcs_pkg::EXT_W-1:0]   et_reg, eb_reg, el_reg, er_reg;

    always_ff @(posedge aclk) begin
        if (r1) begin
            px_reg <= s_tdata[23:0];
            py_reg <= s_tdata[47:24];
            nx_reg <= s_tdata[71:48];
            ny_reg <= s_tdata[95:72];
            vx_reg <= s_tdata[119:96];
            vy_reg <= s_tdata[143:120];
            ox_reg <= s_tdata[167:144];
            oy_reg <= s_tdata[191:168];
            et_reg <= s_tdata[211:192];
            eb_reg <= s_tdata[231:212];
            el_reg <= s_tdata[251:232];
            er_reg <= s_tdata[271:252];
        end
    end

    // face lines and differences from current position
    logic signed [sbcs_pkg::LINE_W-1:0] yhi, ylo, xlo, xhi;
    logic signed [sbcs_pkg::DIFF_W-1:0] dt_next, db_next, dl_next, dr_next;
    logic signed [sbcs_pkg::DIFF_W-1:0] nt, nb, nl, nr;
    logic signed [sbcs_pkg::VEL_W-1:0]  vxn_next, vyn_next, adx_next, ady_next;
    logic ok_t_next, ok_b_next, ok_l_next, ok_r_next;

    always_comb begin
        yhi = sbcs_pkg::LINE_W'(oy_reg) + $signed({6'd0, et_reg});
        ylo = sbcs_pkg::LINE_W'(oy_reg) - $signed({6'd0, eb_reg});
        xlo = sbcs_pkg::LINE_W'(ox_reg) - $signed({6'd0, el_reg});
        xhi = sbcs_pkg::LINE_W'(ox_reg) + $signed({6'd0, er_reg});
        dt_next = sbcs_pkg::DIFF_W'(py_reg) - sbcs_pkg::DIFF_W'(yhi);
        db_next = sbcs_pkg::DIFF_W'(py_reg) - sbcs_pkg::DIFF_W'(ylo);
        dl_next = sbcs_pkg::DIFF_W'(px_reg) - sbcs_pkg::DIFF_W'(xlo);
        dr_next = sbcs_pkg::DIFF_W'(px_reg) - sbcs_pkg::DIFF_W'(xhi);
        nt = sbcs_pkg::DIFF_W'(ny_reg) - sbcs_pkg::DIFF_W'(yhi);
        nb = sbcs_pkg::DIFF_W'(ny_reg) - sbcs_pkg::DIFF_W'(ylo);
        nl = sbcs_pkg::DIFF_W'(nx_reg) - sbcs_pkg::DIFF_W'(xlo);
        nr = sbcs_pkg::DIFF_W'(nx_reg) - sbcs_pkg::DIFF_W'(xhi);
        // fold the divisor sign into the other velocity
        vxn_next = vy_reg[sbcs_pkg::COORD_W-1] ? -sbcs_pkg::VEL_W'(vx_reg)
                                               : sbcs_pkg::VEL_W'(vx_reg);
        ady_next = vy_reg[sbcs_pkg::COORD_W-1] ? -sbcs_pkg::VEL_W'(vy_reg)
                                               : sbcs_pkg::VEL_W'(vy_reg);
        vyn_next = vx_reg[sbcs_pkg::COORD_W-1] ? -sbcs_pkg::VEL_W'(vy_reg)
                                               : sbcs_pkg::VEL_W'(vy_reg);
        adx_next = vx_reg[sbcs_pkg::COORD_W-1] ? -sbcs_pkg::VEL_W'(vx_reg)
                                               : sbcs_pkg::VEL_W'(vx_reg);
        ok_t_next = (vy_reg != '0) && (dt_next >= 0) && (nt <= 0);
        ok_b_next = (vy_reg != '0) && (db_next <= 0) && (nb >= 0);
        ok_l_next = (vx_reg != '0) && (dl_next <= 0) && (nl >= 0);
        ok_r_next = (vx_reg != '0) && (dr_next >= 0) && (nr <= 0);
    end

    // stage 2
    logic signed [sbcs_pkg::DIFF_W-1:0] dt_reg, db_reg, dl_reg, dr_reg;
    logic signed [sbcs_pkg::VEL_W-1:0]  vxn_reg, vyn_reg, adx_reg, ady_reg;
    logic ok_t_reg, ok_b_reg, ok_l_reg, ok_r_reg;

    always_ff @(posedge aclk) begin
        if (r2) begin
            dt_reg <= dt_next; db_reg <= db_next;
            dl_reg <= dl_next; dr_reg <= dr_next;
            vxn_reg <= vxn_next; vyn_reg <= vyn_next;
            adx_reg <= adx_next; ady_reg <= ady_next;
            ok_t_reg <= ok_t_next; ok_b_reg <= ok_b_next;
            ok_l_reg <= ok_l_next; ok_r_reg <= ok_r_next;
        end
    end

    // stage 3: cross products
    // top/bottom faces: num = d*vxn, bounds (px-xlo)*|vy|, (px-xhi)*|vy|
    // left/right faces: num = d*vyn, bounds (py-ylo)*|vx|, (py-yhi)*|vx|
    logic signed [sbcs_pkg::PROD_W-1:0] nt_reg, nb_reg, lov_reg, hiv_reg;
    logic signed [sbcs_pkg::PROD_W-1:0] nl_reg, nr_reg, loh_reg, hih_reg;
    logic ok3_t_reg, ok3_b_reg, ok3_l_reg, ok3_r_reg;

    always_ff @(posedge aclk) begin
        if (r3) begin
            nt_reg  <= sbcs_pkg::PROD_W'(dt_reg) * sbcs_pkg::PROD_W'(vxn_reg);
            nb_reg  <= sbcs_pkg::PROD_W'(db_reg) * sbcs_pkg::PROD_W'(vxn_reg);
            lov_reg <= sbcs_pkg::PROD_W'(dl_reg) * sbcs_pkg::PROD_W'(ady_reg);
            hiv_reg <= sbcs_pkg::PROD_W'(dr_reg) * sbcs_pkg::PROD_W'(ady_reg);
            nl_reg  <= sbcs_pkg::PROD_W'(dl_reg) * sbcs_pkg::PROD_W'(vyn_reg);
            nr_reg  <= sbcs_pkg::PROD_W'(dr_reg) * sbcs_pkg::PROD_W'(vyn_reg);
            loh_reg <= sbcs_pkg::PROD_W'(db_reg) * sbcs_pkg::PROD_W'(adx_reg);
            hih_reg <= sbcs_pkg::PROD_W'(dt_reg) * sbcs_pkg::PROD_W'(adx_reg);
            ok3_t_reg <= ok_t_reg; ok3_b_reg <= ok_b_reg;
            ok3_l_reg <= ok_l_reg; ok3_r_reg <= ok_r_reg;
        end
    end

    // stage 4: span checks and fixed priority top, bottom, left, right
    logic hit_t, hit_b, hit_l, hit_r;
    logic [sbcs_pkg::SIDE_W-1:0] side_next, side_reg;

    always_comb begin
        hit_t = ok3_t_reg && (lov_reg >= nt_reg) && (hiv_reg <= nt_reg);
        hit_b = ok3_b_reg && (lov_reg >= nb_reg) && (hiv_reg <= nb_reg);
        hit_l = ok3_l_reg && (loh_reg >= nl_reg) && (hih_reg <= nl_reg);
        hit_r = ok3_r_reg && (loh_reg >= nr_reg) && (hih_reg <= nr_reg);
        if (hit_t)      side_next = sbcs_pkg::SIDE_TOP;
        else if (hit_b) side_next = sbcs_pkg::SIDE_BOTTOM;
        else if (hit_l) side_next = sbcs_pkg::SIDE_LEFT;
        else if (hit_r) side_next = sbcs_pkg::SIDE_RIGHT;
        else            side_next = sbcs_pkg::SIDE_NONE;
    end

    always_ff @(posedge aclk) begin
        if (r4) begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= s_tvalid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {5'd0, side_reg};

    `SBCS_ASSERT_IMPLY(a_side_range, aclk, aresetn, m_tvalid, side_reg <= sbcs_pkg::SIDE_LEFT)
    `SBCS_ASSERT_NEXT(a_stage1_hold, aclk, aresetn, v1_reg && !r2, v1_reg)
    `SBCS_ASSERT_NEXT(a_stage3_hold, aclk, aresetn, v3_reg && !r4, v3_reg)
    `SBCS_ASSERT_IMPLY(a_no_hit_no_cross, aclk, aresetn, v3_reg && !ok3_t_reg && !ok3_b_reg && !ok3_l_reg && !ok3_r_reg, side_next == sbcs_pkg::SIDE_NONE)

endmodule

// File: tb/tb_swept_box_collision_side_unit.sv
// Testbench for the swept box collision side unit: directed and random pair tests
// with a face-hit predictor and an in-order scoreboard. Depends on sbcs_pkg and the RTL.
module tb_swept_box_collision_side_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // one pair test as driven on s_tdata
    typedef struct packed {
        logic [sbcs_pkg::EXT_W-1:0]   ext_r;
        logic [sbcs_pkg::EXT_W-1:0]   ext_l;
        logic [sbcs_pkg::EXT_W-1:0]   ext_b;
        logic [sbcs_pkg::EXT_W-1:0]   ext_t;
        logic [sbcs_pkg::COORD_W-1:0] oy;
        logic [sbcs_pkg::COORD_W-1:0] ox;
        logic [sbcs_pkg::COORD_W-1:0] vy;
        logic [sbcs_pkg::COORD_W-1:0] vx;
        logic [sbcs_pkg::COORD_W-1:0] ny;
        logic [sbcs_pkg::COORD_W-1:0] nx;
        logic [sbcs_pkg::COORD_W-1:0] py;
        logic [sbcs_pkg::COORD_W-1:0] px;
    } pair_t;

    // exact rational test: p - d*vp/vq inside [lo, hi]
    function automatic bit crossing_in_span(longint p, longint d, longint vp, longint vq,
                                            longint lo, longint hi);
        longint num, den;
        num = d * vp;
        den = vq;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        return ((p - lo) * den >= num) && ((p - hi) * den <= num);
    endfunction

    function automatic logic [sbcs_pkg::SIDE_W-1:0] predict_face(pair_t b);
        longint px, py, nx, ny, vx, vy, xlo, xhi, ylo, yhi;
        logic [sbcs_pkg::SIDE_W-1:0] face;
        px = longint'($signed(b.px));  py = longint'($signed(b.py));
        nx = longint'($signed(b.nx));  ny = longint'($signed(b.ny));
        vx = longint'($signed(b.vx));  vy = longint'($signed(b.vy));
        xlo = longint'($signed(b.ox)) - longint'(b.ext_l);
        xhi = longint'($signed(b.ox)) + longint'(b.ext_r);
        ylo = longint'($signed(b.oy)) - longint'(b.ext_b);
        yhi = longint'($signed(b.oy)) + longint'(b.ext_t);
        face = sbcs_pkg::SIDE_NONE;
        if (vy != 0) begin
            if (py >= yhi && ny <= yhi && crossing_in_span(px, py - yhi, vx, vy, xlo, xhi))
                face = sbcs_pkg::SIDE_TOP;
            else if (py <= ylo && ny >= ylo &&
                     crossing_in_span(px, py - ylo, vx, vy, xlo, xhi))
                face = sbcs_pkg::SIDE_BOTTOM;
        end
        if (face == sbcs_pkg::SIDE_NONE && vx != 0) begin
            if (px <= xlo && nx >= xlo && crossing_in_span(py, px - xlo, vy, vx, ylo, yhi))
                face = sbcs_pkg::SIDE_LEFT;
            else if (px >= xhi && nx <= xhi &&
                     crossing_in_span(py, px - xhi, vy, vx, ylo, yhi))
                face = sbcs_pkg::SIDE_RIGHT;
        end
        return face;
    endfunction

    class face_scoreboard;
        logic [sbcs_pkg::SIDE_W-1:0] faces_due[$];
        int errors;
        function void note_pair(pair_t b);
            faces_due = {faces_due, predict_face(b)};
        endfunction
        function void check_face(logic [sbcs_pkg::OUT_W-1:0] d);
            logic [sbcs_pkg::SIDE_W-1:0] want;
            if (faces_due.size() == 0) begin
                $error("unexpected result beat, hit_side %0d", d[sbcs_pkg::SIDE_W-1:0]);
                errors++;
                return;
            end
            want = faces_due.pop_front();
            if (d[sbcs_pkg::SIDE_W-1:0] !== want) begin
                $error("hit_side mismatch: expected %0d actual %0d", want,
                       d[sbcs_pkg::SIDE_W-1:0]);
                errors++;
            end
            if (d[sbcs_pkg::OUT_W-1:sbcs_pkg::SIDE_W] !== '0) begin
                $error("pad mismatch: expected 0 actual %0h",
                       d[sbcs_pkg::OUT_W-1:sbcs_pkg::SIDE_W]);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, m_tready = 0;
    logic s_tready, m_tvalid;
    logic [sbcs_pkg::IN_W-1:0] s_tdata = '0;
    logic [sbcs_pkg::OUT_W-1:0] m_tdata;

    face_scoreboard sb = new();
    int src_idle_pct = 0, dst_idle_pct = 0;
    bit hold_off = 0;
    bit stim_done = 0;

    always #10 aclk = ~aclk;

    swept_box_collision_side_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // sample both handshakes at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_pair(pair_t'(s_tdata));
        if (aresetn && m_tvalid && m_tready) sb.check_face(m_tdata);
    end

    // receiver: random stalls, or a long counted hold-off
    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic send_pair(pair_t b);
        @(negedge aclk);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [sbcs_pkg::COORD_W-1:0] rnd_near(longint c, int span);
        return sbcs_pkg::COORD_W'(c + longint'($urandom_range(2 * span)) - span);
    endfunction

    // mostly geometric cases built around the obstacle so faces get hit
    function automatic pair_t rnd_pair();
        pair_t b;
        int span, mode;
        longint ox, oy;
        logic [287:0] rbits;
        mode = $urandom_range(9);
        span = (mode < 7) ? 4000 : 8388607;
        rbits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        b = rbits[sbcs_pkg::IN_W-1:0];
        if (mode < 7) begin
            ox = longint'($signed(b.ox)); oy = longint'($signed(b.oy));
            b.ext_t = sbcs_pkg::EXT_W'($urandom_range(2000));
            b.ext_b = sbcs_pkg::EXT_W'($urandom_range(2000));
            b.ext_l = sbcs_pkg::EXT_W'($urandom_range(2000));
            b.ext_r = sbcs_pkg::EXT_W'($urandom_range(2000));
            b.px = rnd_near(ox, span); b.py = rnd_near(oy, span);
            b.nx = rnd_near(ox, span); b.ny = rnd_near(oy, span);
            b.vx = sbcs_pkg::COORD_W'($signed(b.nx) - $signed(b.px));
            b.vy = sbcs_pkg::COORD_W'($signed(b.ny) - $signed(b.py));
            if ($urandom_range(7) == 0) b.vx = '0;
            if ($urandom_range(7) == 0) b.vy = '0;
            if ($urandom_range(3) == 0) b.vx = rnd_near(0, 600);
        end
        return b;
    endfunction

    function automatic pair_t mk(int px, int py, int nx, int ny, int vx, int vy,
                                 int ox, int oy, int et, int eb, int el, int er);
        pair_t b;
        b.px = sbcs_pkg::COORD_W'(px); b.py = sbcs_pkg::COORD_W'(py);
        b.nx = sbcs_pkg::COORD_W'(nx); b.ny = sbcs_pkg::COORD_W'(ny);
        b.vx = sbcs_pkg::COORD_W'(vx); b.vy = sbcs_pkg::COORD_W'(vy);
        b.ox = sbcs_pkg::COORD_W'(ox); b.oy = sbcs_pkg::COORD_W'(oy);
        b.ext_t = sbcs_pkg::EXT_W'(et); b.ext_b = sbcs_pkg::EXT_W'(eb);
        b.ext_l = sbcs_pkg::EXT_W'(el); b.ext_r = sbcs_pkg::EXT_W'(er);
        return b;
    endfunction

    task automatic run_phase(int n);
        repeat (n) send_pair(rnd_pair());
    endtask

    initial begin
        pair_t b;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;
        // directed: each face, corners (inclusive span), zero speeds, extremes
        send_pair(mk(0, 600, 0, -600, 0, -1200, 0, 0, 256, 256, 256, 256));   // top
        send_pair(mk(0, -600, 0, 600, 0, 1200, 0, 0, 256, 256, 256, 256));    // bottom
        send_pair(mk(-600, 0, 600, 0, 1200, 0, 0, 0, 256, 256, 256, 256));    // left
        send_pair(mk(600, 0, -600, 0, -1200, 0, 0, 0, 256, 256, 256, 256));   // right
        send_pair(mk(512, 512, 0, 0, -512, -512, 0, 0, 256, 256, 256, 256));  // corner
        send_pair(mk(256, 512, 256, 0, 0, -512, 0, 0, 256, 256, 256, 256));   // span end
        send_pair(mk(257, 512, 257, 0, 0, -512, 0, 0, 256, 256, 256, 256));   // just out
        send_pair(mk(0, 600, 0, -600, 0, 0, 0, 0, 256, 256, 256, 256));       // vy zero
        send_pair(mk(-600, 0, 600, 0, 0, 0, 0, 0, 256, 256, 256, 256));       // both zero
        send_pair(mk(0, 256, 0, 256, 0, -1, 0, 0, 256, 256, 256, 256));       // on line
        send_pair(mk(8388607, 8388607, -8388608, -8388608, -8388608, -8388608,
                     0, 0, 1048575, 1048575, 1048575, 1048575));
        send_pair(mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
                     8388607, -8388608, 0, 0, 0, 0));
        send_pair(mk(-8388608, 8388607, 8388607, -8388608, 8388607, -8388608,
                     -8388608, 8388607, 1048575, 0, 1048575, 0));
        send_pair(mk(0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0));
        b = '1; send_pair(b);
        b = '0; send_pair(b);
        src_idle_pct = 15; dst_idle_pct = 68;
        run_phase(200);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (60) @(posedge aclk);
                hold_off = 0;
            end
            run_phase(40);
        join
        src_idle_pct = 68; dst_idle_pct = 15;
        run_phase(270);
        src_idle_pct = 0; dst_idle_pct = 0;
        run_phase(270);
        @(negedge aclk) s_tvalid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.faces_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.faces_due.size() == 0)
            $display("tb_swept_box_collision_side_unit: clean");
        else
            $display("tb_swept_box_collision_side_unit: errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_swept_box_collision_side_unit: errors");
        $finish;
    end
endmodule
